>>> src/tcws_pkg.sv
package tcws_pkg;

  localparam int unsigned CELL_W     = 8;
  localparam int unsigned COORD_W    = 8;
  localparam int unsigned ACTION_W   = 2;
  localparam int unsigned GRID_W_W   = 9;
  localparam int unsigned PASS_W     = 4;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 9;

  localparam logic [GRID_W_W-1:0] GRID_WIDTH_RST = 9'd160;
  localparam logic [PASS_W-1:0]   PASS_COUNT_RST = 4'd4;

  typedef enum logic [ACTION_W-1:0] {
    ACT_WRITE = 2'd0,
    ACT_RUN   = 2'd1,
    ACT_READ  = 2'd2
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_WIDTH = 1'b0,
    CFG_PASS_COUNT = 1'b1
  } cfg_idx_t;

  typedef logic [CELL_W-1:0] cell_t;

endpackage

>>> src/tcws_in_if.sv
interface tcws_in_if import tcws_pkg::*;;
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [COORD_W-1:0]  row;
  logic [COORD_W-1:0]  col;
  cell_t               cell_value;

  modport source (output valid, output action, output row, output col, output cell_value,
                  input ready);
  modport sink (input valid, input action, input row, input col, input cell_value,
                output ready);
endinterface

>>> src/tcws_out_if.sv
interface tcws_out_if import tcws_pkg::*;;
  logic  valid;
  logic  ready;
  cell_t read_value;
  logic  run_done;

  modport source (output valid, output read_value, output run_done, input ready);
  modport sink (input valid, input read_value, input run_done, output ready);
endinterface

>>> src/tcws_cfg_if.sv
interface tcws_cfg_if import tcws_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> src/toroidal_corner_weighted_smoother_unit.sv
// Toroidal 9-3-3-1 smoother over a square grid of 8-bit cells held in one single-port
// synchronous RAM of MAX_WIDTH*MAX_WIDTH entries (row-major, cells never cleared, so
// load every cell of the active grid before a run). A write item's result is registered
// on acceptance; a read item passes S_RDRESP first, as the RAM read is registered.
// A run item walks, for each pass and each size, the corners stepping by the size from
// the running offset; each corner runs S_SETUP to set up the wrapped coordinates, S_R0
// to S_R3 for four RAM reads, S_CAP to form the weighted averages and S_W0 to S_W3 for
// four RAM writes, all through the one RAM port. One item is worked on at a time;
// configuration writes are taken in any cycle and every item yields exactly one result.
module toroidal_corner_weighted_smoother_unit import tcws_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 256
) (
  input  logic         clk,
  input  logic         rst_n,
  tcws_in_if.sink      in_ch,
  tcws_out_if.source   out_ch,
  tcws_cfg_if.sink     cfg_ch
);

  localparam int unsigned WCAP  = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
  localparam int unsigned CW    = $clog2(WCAP);
  localparam int unsigned WW    = $clog2(WCAP + 1);
  localparam int unsigned DEPTH = MAX_WIDTH * MAX_WIDTH;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned SUM_W = 12;
  localparam logic [SUM_W-1:0] WT_NEAR = 12'd9;
  localparam logic [SUM_W-1:0] WT_SIDE = 12'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_RDRESP, S_SETUP, S_R0, S_R1, S_R2, S_R3, S_CAP, S_W0, S_W1, S_W2, S_W3
  } state_t;

  state_t               state_r;
  logic [GRID_W_W-1:0]  grid_width_r;
  logic [PASS_W-1:0]    pass_count_r;
  logic [PASS_W-1:0]    p_r;
  logic [WW-1:0]        sz_r;
  logic [CW-1:0]        off_r;
  logic [CW-1:0]        x1_r, y1_r, x2_r, y2_r, x3_r, y3_r, x4_r, y4_r;
  cell_t                a_r, b_r, c_r;
  cell_t                q1_r, q2_r, q3_r, q4_r;
  logic                 rd_inside_r;
  logic                 out_valid_r;
  cell_t                out_read_value_r;
  logic                 out_run_done_r;

  cell_t                mem [DEPTH];
  cell_t                mem_rdata_r;
  logic [AW-1:0]        mem_addr;
  cell_t                mem_wdata;
  logic                 mem_we;

  logic [WW-1:0]        eff_w;
  logic                 in_acc, cfg_acc, in_inside;
  logic [WW:0]          x_next, y_next;
  logic                 x_more, y_more, size_more, pass_more;
  logic [WW-1:0]        sz_half;
  logic [CW-1:0]        off_new;
  logic [SUM_W-1:0]     s1, s2, s3, s4;
  logic                 res_load;

  function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] r, input logic [CW-1:0] c);
    addr_of = AW'(r) * AW'(MAX_WIDTH) + AW'(c);
  endfunction

  function automatic logic [CW-1:0] wrap(input logic [WW:0] s, input logic [WW-1:0] w);
    logic [WW:0] d;
    d = s - {1'b0, w};
    wrap = (s >= {1'b0, w}) ? d[CW-1:0] : s[CW-1:0];
  endfunction

  always_comb begin
    if (grid_width_r < 9'd2) begin
      eff_w = WW'(2);
    end else if (grid_width_r > GRID_W_W'(WCAP)) begin
      eff_w = WW'(WCAP);
    end else begin
      eff_w = grid_width_r[WW-1:0];
    end
  end

  assign in_ch.ready   = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign cfg_ch.ready  = 1'b1;
  assign in_acc        = in_ch.valid && in_ch.ready;
  assign cfg_acc       = cfg_ch.valid && cfg_ch.ready;
  assign in_inside     = ({1'b0, in_ch.row} < 9'(eff_w)) && ({1'b0, in_ch.col} < 9'(eff_w));

  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_value = out_read_value_r;
  assign out_ch.run_done   = out_run_done_r;

  assign y_next    = (WW+1)'(y1_r) + (WW+1)'(sz_r);
  assign x_next    = (WW+1)'(x1_r) + (WW+1)'(sz_r);
  assign y_more    = y_next < (WW+1)'(eff_w);
  assign x_more    = x_next < (WW+1)'(eff_w);
  assign sz_half   = sz_r >> 1;
  assign size_more = sz_half > WW'(1);
  assign off_new   = CW'(sz_r >> 2);
  assign pass_more = ((PASS_W+1)'(p_r) + (PASS_W+1)'(1)) < (PASS_W+1)'(pass_count_r);

  assign res_load = ((state_r == S_IDLE) && in_acc && (in_ch.action != ACT_READ)
                     && !((in_ch.action == ACT_RUN) && (pass_count_r != '0)))
                  || (state_r == S_RDRESP)
                  || ((state_r == S_W3) && !y_more && !x_more && !size_more && !pass_more);

  assign s1 = SUM_W'(a_r) * WT_NEAR + SUM_W'(b_r) * WT_SIDE + SUM_W'(c_r) * WT_SIDE
            + SUM_W'(mem_rdata_r);
  assign s2 = SUM_W'(a_r) * WT_SIDE + SUM_W'(b_r) * WT_NEAR + SUM_W'(c_r)
            + SUM_W'(mem_rdata_r) * WT_SIDE;
  assign s3 = SUM_W'(a_r) * WT_SIDE + SUM_W'(b_r) + SUM_W'(c_r) * WT_NEAR
            + SUM_W'(mem_rdata_r) * WT_SIDE;
  assign s4 = SUM_W'(a_r) + SUM_W'(b_r) * WT_SIDE + SUM_W'(c_r) * WT_SIDE
            + SUM_W'(mem_rdata_r) * WT_NEAR;

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = addr_of(x1_r, y1_r);
    mem_wdata = q1_r;
    case (state_r)
      S_IDLE: begin
        mem_addr  = addr_of(in_ch.row[CW-1:0], in_ch.col[CW-1:0]);
        mem_wdata = in_ch.cell_value;
        mem_we    = in_acc && (in_ch.action == ACT_WRITE) && in_inside;
      end
      S_R0: mem_addr = addr_of(x1_r, y1_r);
      S_R1: mem_addr = addr_of(x2_r, y1_r);
      S_R2: mem_addr = addr_of(x1_r, y2_r);
      S_R3: mem_addr = addr_of(x2_r, y2_r);
      S_W0: begin
        mem_addr  = addr_of(x3_r, y3_r);
        mem_wdata = q1_r;
        mem_we    = 1'b1;
      end
      S_W1: begin
        mem_addr  = addr_of(x4_r, y3_r);
        mem_wdata = q2_r;
        mem_we    = 1'b1;
      end
      S_W2: begin
        mem_addr  = addr_of(x3_r, y4_r);
        mem_wdata = q3_r;
        mem_we    = 1'b1;
      end
      S_W3: begin
        mem_addr  = addr_of(x4_r, y4_r);
        mem_wdata = q4_r;
        mem_we    = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    mem_rdata_r <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      grid_width_r <= GRID_WIDTH_RST;
      pass_count_r <= PASS_COUNT_RST;
    end else begin
      if (cfg_acc) begin
        case (cfg_ch.index)
          CFG_GRID_WIDTH: grid_width_r <= cfg_ch.data;
          CFG_PASS_COUNT: pass_count_r <= cfg_ch.data[PASS_W-1:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready && !res_load) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            case (in_ch.action)
              ACT_READ: begin
                rd_inside_r <= in_inside;
                state_r     <= S_RDRESP;
              end
              ACT_RUN: begin
                if (pass_count_r == '0) begin
                  out_valid_r      <= 1'b1;
                  out_read_value_r <= '0;
                  out_run_done_r   <= 1'b1;
                end else begin
                  p_r     <= '0;
                  sz_r    <= eff_w;
                  off_r   <= '0;
                  x1_r    <= '0;
                  y1_r    <= '0;
                  state_r <= S_SETUP;
                end
              end
              default: begin
                out_valid_r      <= 1'b1;
                out_read_value_r <= '0;
                out_run_done_r   <= 1'b0;
              end
            endcase
          end
        end
        S_RDRESP: begin
          out_valid_r      <= 1'b1;
          out_read_value_r <= rd_inside_r ? mem_rdata_r : '0;
          out_run_done_r   <= 1'b0;
          state_r          <= S_IDLE;
        end
        S_SETUP: begin
          x2_r    <= wrap(x_next, eff_w);
          y2_r    <= wrap(y_next, eff_w);
          x3_r    <= wrap((WW+1)'(x1_r) + (WW+1)'(sz_r >> 2), eff_w);
          y3_r    <= wrap((WW+1)'(y1_r) + (WW+1)'(sz_r >> 2), eff_w);
          state_r <= S_R0;
        end
        S_R0: begin
          x4_r    <= wrap((WW+1)'(x3_r) + (WW+1)'(sz_half), eff_w);
          y4_r    <= wrap((WW+1)'(y3_r) + (WW+1)'(sz_half), eff_w);
          state_r <= S_R1;
        end
        S_R1: begin
          a_r     <= mem_rdata_r;
          state_r <= S_R2;
        end
        S_R2: begin
          b_r     <= mem_rdata_r;
          state_r <= S_R3;
        end
        S_R3: begin
          c_r     <= mem_rdata_r;
          state_r <= S_CAP;
        end
        S_CAP: begin
          q1_r    <= s1[SUM_W-1:4];
          q2_r    <= s2[SUM_W-1:4];
          q3_r    <= s3[SUM_W-1:4];
          q4_r    <= s4[SUM_W-1:4];
          state_r <= S_W0;
        end
        S_W0: state_r <= S_W1;
        S_W1: state_r <= S_W2;
        S_W2: state_r <= S_W3;
        S_W3: begin
          state_r <= S_SETUP;
          if (y_more) begin
            y1_r <= y_next[CW-1:0];
          end else if (x_more) begin
            x1_r <= x_next[CW-1:0];
            y1_r <= off_r;
          end else if (size_more) begin
            sz_r  <= sz_half;
            off_r <= off_new;
            x1_r  <= off_new;
            y1_r  <= off_new;
          end else if (pass_more) begin
            p_r   <= p_r + PASS_W'(1);
            sz_r  <= eff_w;
            off_r <= off_new;
            x1_r  <= off_new;
            y1_r  <= off_new;
          end else begin
            out_valid_r      <= 1'b1;
            out_read_value_r <= '0;
            out_run_done_r   <= 1'b1;
            state_r          <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_write_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_ch.action == ACT_WRITE)) |=> (out_valid_r && !out_run_done_r))
    else $error("write item gave no result");

  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_ch.action == ACT_READ)) |-> ##2 (out_valid_r && !out_run_done_r))
    else $error("read item gave no result");

  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_run_done_r) |-> (out_read_value_r == '0))
    else $error("run result carries a cell value");

  a_corner_inside: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SETUP) |-> ((WW'(x1_r) < eff_w) && (WW'(y1_r) < eff_w)))
    else $error("corner outside grid");

  a_wrap_inside: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_R1) |-> ((WW'(x2_r) < eff_w) && (WW'(y2_r) < eff_w)
                           && (WW'(x4_r) < eff_w) && (WW'(y4_r) < eff_w)))
    else $error("wrapped coordinate outside grid");
`endif

endmodule

>>> tb/tcws_smoother_checker.sv
module tcws_smoother_checker import tcws_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 256
) (
  input  logic clk,
  input  logic rst_n,
  tcws_in_if   in_ch,
  tcws_out_if  out_ch,
  tcws_cfg_if  cfg_ch,
  output int   fail_count,
  output int   pending_count,
  output int   results_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SIDE_CAP = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;

  typedef struct packed {
    cell_t read_value;
    logic  run_done;
  } cell_result_t;

  cell_t               grid_model [MAX_WIDTH*MAX_WIDTH];
  logic [GRID_W_W-1:0] side_reg;
  logic [PASS_W-1:0]   pass_reg;
  cell_result_t        expected_results [$];
  int                  errors;
  int                  checked;

  initial begin
    errors   = 0;
    checked  = 0;
    side_reg = GRID_WIDTH_RST;
    pass_reg = PASS_COUNT_RST;
    foreach (grid_model[i]) grid_model[i] = '0;
  end

  function automatic int unsigned active_side();
    int unsigned w;
    w = side_reg;
    if (w < 2) w = 2;
    if (w > SIDE_CAP) w = SIDE_CAP;
    return w;
  endfunction

  function automatic int unsigned cell_index(int unsigned r, int unsigned c);
    return r * MAX_WIDTH + c;
  endfunction

  task automatic smooth_grid();
    int unsigned w, offset, sz;
    int unsigned x1, y1, x2, y2, x3, y3, x4, y4;
    int unsigned a, b, c, d;
    w      = active_side();
    offset = 0;
    for (int p = 0; p < pass_reg; p++) begin
      for (sz = w; sz > 1; sz = sz / 2) begin
        for (x1 = offset; x1 < w; x1 += sz) begin
          for (y1 = offset; y1 < w; y1 += sz) begin
            x2 = (x1 + sz) % w;
            y2 = (y1 + sz) % w;
            a  = grid_model[cell_index(x1, y1)];
            b  = grid_model[cell_index(x2, y1)];
            c  = grid_model[cell_index(x1, y2)];
            d  = grid_model[cell_index(x2, y2)];
            x3 = (x1 + sz / 4) % w;
            y3 = (y1 + sz / 4) % w;
            x4 = (x3 + sz / 2) % w;
            y4 = (y3 + sz / 2) % w;
            grid_model[cell_index(x3, y3)] = CELL_W'((a * 9 + b * 3 + c * 3 + d) / 16);
            grid_model[cell_index(x4, y3)] = CELL_W'((a * 3 + b * 9 + c + d * 3) / 16);
            grid_model[cell_index(x3, y4)] = CELL_W'((a * 3 + b + c * 9 + d * 3) / 16);
            grid_model[cell_index(x4, y4)] = CELL_W'((a + b * 3 + c * 3 + d * 9) / 16);
          end
        end
        offset = sz / 4;
      end
    end
  endtask

  task automatic note_mismatch(string field, int want, int got);
    errors++;
    if (errors <= 10)
      $display("[%0t] %s mismatch: expected %0d, got %0d", $realtime, field, want, got);
  endtask

  always @(posedge clk) begin
    cell_result_t want;
    int unsigned  side;
    if (!rst_n) begin
      side_reg = GRID_WIDTH_RST;
      pass_reg = PASS_COUNT_RST;
      expected_results.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        checked++;
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("[%0t] result with nothing expected: read_value %0d run_done %0b",
                     $realtime, out_ch.read_value, out_ch.run_done);
        end else begin
          want = expected_results.pop_front();
          if (out_ch.read_value !== want.read_value)
            note_mismatch("read_value", want.read_value, out_ch.read_value);
          if (out_ch.run_done !== want.run_done)
            note_mismatch("run_done", want.run_done, out_ch.run_done);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        side = active_side();
        want = '0;
        case (in_ch.action)
          ACT_WRITE: begin
            if (in_ch.row < side && in_ch.col < side)
              grid_model[cell_index(in_ch.row, in_ch.col)] = in_ch.cell_value;
          end
          ACT_RUN: begin
            smooth_grid();
            want.run_done = 1'b1;
          end
          ACT_READ: begin
            if (in_ch.row < side && in_ch.col < side)
              want.read_value = grid_model[cell_index(in_ch.row, in_ch.col)];
          end
          default: ;
        endcase
        expected_results.push_back(want);
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_GRID_WIDTH: side_reg = cfg_ch.data[GRID_W_W-1:0];
          CFG_PASS_COUNT: pass_reg = cfg_ch.data[PASS_W-1:0];
          default: ;
        endcase
      end
    end
    fail_count      <= errors;
    pending_count   <= expected_results.size();
    results_checked <= checked;
  end

endmodule

>>> tb/tb_toroidal_corner_weighted_smoother_unit.sv
module tb_toroidal_corner_weighted_smoother_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import tcws_pkg::*;

  localparam int unsigned MAX_W         = 256;
  localparam int unsigned CLK_PERIOD    = 12;
  localparam int          RANDOM_ITEMS  = 1300;
  localparam longint      CYCLE_LIMIT   = 30_000_000;
  localparam int unsigned FILL_MAX_SIDE = 16;
  localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  logic clk = 1'b0;
  logic rst_n;

  tcws_in_if  in_ch ();
  tcws_out_if out_ch ();
  tcws_cfg_if cfg_ch ();

  toroidal_corner_weighted_smoother_unit #(.MAX_WIDTH(MAX_W)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  int fail_count;
  int pending_count;
  int results_checked;

  tcws_smoother_checker #(.MAX_WIDTH(MAX_W)) grid_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .cfg_ch          (cfg_ch),
    .fail_count      (fail_count),
    .pending_count   (pending_count),
    .results_checked (results_checked)
  );

  int          send_gap_pct   = 0;
  int          recv_stall_pct = 0;
  int unsigned side;
  int unsigned passes;
  bit          cell_written [MAX_W*MAX_W];
  int unsigned written_cells [$];
  int          loads, reads, runs, spares, settings_applied, random_items;
  longint      cycle_count = 0;

  always #(CLK_PERIOD/2) clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(negedge clk) out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

  function automatic int unsigned clamp_side(int unsigned raw);
    if (raw < 2) return 2;
    if (raw > MAX_W) return MAX_W;
    return raw;
  endfunction

  task automatic send_item(logic [ACTION_W-1:0] act, int unsigned r, int unsigned c,
                           int unsigned v);
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.action     <= act;
    in_ch.row        <= COORD_W'(r);
    in_ch.col        <= COORD_W'(c);
    in_ch.cell_value <= CELL_W'(v);
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    case (act)
      ACT_WRITE: loads++;
      ACT_READ:  reads++;
      ACT_RUN:   runs++;
      default:   spares++;
    endcase
  endtask

  task automatic put_cell(int unsigned r, int unsigned c, int unsigned v);
    send_item(ACT_WRITE, r, c, v);
    if (r < side && c < side && !cell_written[r*MAX_W+c]) begin
      cell_written[r*MAX_W+c] = 1'b1;
      written_cells.push_back(r*MAX_W+c);
    end
  endtask

  task automatic get_cell(int unsigned r, int unsigned c);
    send_item(ACT_READ, r, c, $urandom_range(255));
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, int unsigned val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= CFG_DATA_W'(val);
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  task automatic apply_settings(int unsigned side_raw, int unsigned pass_val);
    drain_results();
    if ($urandom_range(1)) begin
      write_reg(CFG_GRID_WIDTH, side_raw);
      write_reg(CFG_PASS_COUNT, pass_val);
    end else begin
      write_reg(CFG_PASS_COUNT, pass_val);
      write_reg(CFG_GRID_WIDTH, side_raw);
    end
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    side   = clamp_side(side_raw);
    passes = pass_val;
    settings_applied++;
  endtask

  task automatic fill_grid();
    for (int unsigned r = 0; r < side; r++)
      for (int unsigned c = 0; c < side; c++)
        if (!cell_written[r*MAX_W+c]) begin
          put_cell(r, c, $urandom_range(255));
          random_items++;
        end
  endtask

  initial begin
    int unsigned side_raw, pass_val, r, c, addr, pick;
    int          phase, n, run_budget;
    bit          filled;
    in_ch.valid      = 1'b0;
    in_ch.action     = ACT_WRITE;
    in_ch.row        = '0;
    in_ch.col        = '0;
    in_ch.cell_value = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = CFG_GRID_WIDTH;
    cfg_ch.data      = '0;
    rst_n            = 1'b0;
    side             = clamp_side(GRID_WIDTH_RST);
    passes           = PASS_COUNT_RST;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // corners of the reset-size grid, outside writes and reads, unused action
    put_cell(0, 0, 255);
    put_cell(159, 159, 0);
    put_cell(0, 159, 8'h55);
    put_cell(159, 0, 8'hAA);
    put_cell(255, 255, 8'hAA);
    get_cell(0, 0);
    get_cell(159, 159);
    get_cell(0, 159);
    get_cell(159, 0);
    get_cell(255, 255);
    get_cell(160, 0);
    send_item(ACT_SPARE, 255, 255, 255);

    // zero passes on a grid never filled
    apply_settings(160, 0);
    send_item(ACT_RUN, 0, 0, 0);
    get_cell(0, 0);

    // width below range saturates to the smallest torus
    apply_settings(0, 15);
    put_cell(0, 1, 0);
    put_cell(1, 0, 255);
    put_cell(1, 1, 128);
    send_item(ACT_RUN, 255, 255, 255);
    get_cell(1, 1);
    get_cell(2, 2);
    apply_settings(1, 1);
    send_item(ACT_RUN, 0, 0, 0);
    get_cell(0, 1);

    // width above range saturates to the full store
    apply_settings(511, 0);
    put_cell(255, 255, 8'h3C);
    put_cell(255, 0, 8'hC3);
    get_cell(255, 255);
    get_cell(255, 0);
    send_item(ACT_RUN, 0, 0, 0);

    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      case (idle_mode_t'(phase % 4))
        IDLE_NONE:     begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        IDLE_SENDER:   begin send_gap_pct = 67; recv_stall_pct = 0;  end
        IDLE_RECEIVER: begin send_gap_pct = 0;  recv_stall_pct = 67; end
        default:       begin send_gap_pct = 26; recv_stall_pct = 26; end
      endcase
      pick = $urandom_range(99);
      if (phase == 0)     side_raw = 256;
      else if (pick < 70) side_raw = $urandom_range(12, 0);
      else if (pick < 88) side_raw = $urandom_range(32, 13);
      else                side_raw = $urandom_range(511, 37);
      pick = $urandom_range(7);
      if (pick == 0)      pass_val = 0;
      else if (pick == 1) pass_val = 15;
      else                pass_val = $urandom_range(15);
      apply_settings(side_raw, pass_val);
      filled = (side <= FILL_MAX_SIDE);
      if (filled) fill_grid();
      run_budget = (side <= 16) ? 8 : 2;
      n = $urandom_range(90, 30);
      for (int i = 0; i < n; i++) begin
        if (phase % 3 == 1 && i == n / 2) drain_results();
        pick = $urandom_range(99);
        if (pick < 40) begin
          put_cell($urandom_range(side - 1), $urandom_range(side - 1), $urandom_range(255));
          random_items++;
        end else if (pick < 50) begin
          r = $urandom_range(255);
          c = $urandom_range(255);
          put_cell(r, c, $urandom_range(255));
          if (r < side && c < side) random_items++;
        end else if (pick < 85) begin
          if ($urandom_range(1)) begin
            r = $urandom_range(side - 1);
            c = $urandom_range(side - 1);
          end else begin
            r = $urandom_range(255);
            c = $urandom_range(255);
          end
          // redirect reads of untouched cells to a loaded one
          if (r < side && c < side && !cell_written[r*MAX_W+c]) begin
            addr = written_cells[$urandom_range(written_cells.size() - 1)];
            r    = addr / MAX_W;
            c    = addr % MAX_W;
          end
          get_cell(r, c);
          random_items++;
        end else if (pick < 95) begin
          if ((filled || passes == 0) && run_budget > 0) begin
            send_item(ACT_RUN, $urandom_range(255), $urandom_range(255), $urandom_range(255));
            run_budget--;
          end else begin
            put_cell($urandom_range(side - 1), $urandom_range(side - 1), $urandom_range(255));
          end
          random_items++;
        end else begin
          send_item(ACT_SPARE, $urandom_range(255), $urandom_range(255), $urandom_range(255));
        end
      end
      phase++;
    end

    drain_results();
    repeat (20) @(negedge clk);
    $display("Sent %0d loads, %0d reads, %0d smoothing runs and %0d unused actions",
             loads, reads, runs, spares);
    $display("across %0d register settings; %0d results checked, %0d mismatches",
             settings_applied, results_checked, fail_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> toroidal_corner_weighted_smoother_unit.f
src/tcws_pkg.sv
src/tcws_in_if.sv
src/tcws_out_if.sv
src/tcws_cfg_if.sv
src/toroidal_corner_weighted_smoother_unit.sv
tb/tcws_smoother_checker.sv
tb/tb_toroidal_corner_weighted_smoother_unit.sv
